[src/pedal_plausibility_monitor_core_defines.svh]
// Assertion helpers for the monitor RTL.
`ifndef PEDAL_PLAUSIBILITY_MONITOR_CORE_DEFINES_SVH
`define PEDAL_PLAUSIBILITY_MONITOR_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PPM_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define PPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ppm_pkg.sv]
`timescale 1ns / 1ps

package ppm_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DELTA_W = 16;
  localparam int ELAPSED_W = 20;
  localparam int GAIN_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int STATUS_W = 2;
  localparam int DEMAND_W = 10;
  localparam int FRAC_BITS = 16;

  localparam logic [DEMAND_W-1:0] DEMAND_MAX = 10'd1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Register reset values
  localparam int FIRST_MIN_RST = 310;
  localparam int FIRST_MAX_RST = 2792;
  localparam int SECOND_MIN_RST = 372;
  localparam int SECOND_MAX_RST = 3350;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = 20'd100000;
  localparam logic [GAIN_W-1:0] FIRST_GAIN_RST = 16'd13202;
  localparam logic [GAIN_W-1:0] SECOND_GAIN_RST = 16'd11003;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MAX = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_GAIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_GAIN = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DEMAND = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PENDING = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FAULT = 2'd3;

  typedef struct packed {
    logic mismatch;
    logic out_of_range;
  } item_flags_t;

endpackage

[src/ppm_cfg_regs.sv]
`timescale 1ns / 1ps

module ppm_cfg_regs #(
  parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [ppm_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic [SAMPLE_BITS-1:0]          first_min_code,
  output logic [SAMPLE_BITS-1:0]          first_max_code,
  output logic [SAMPLE_BITS-1:0]          second_min_code,
  output logic [SAMPLE_BITS-1:0]          second_max_code,
  output logic [ppm_pkg::ELAPSED_W-1:0]   timeout_us,
  output logic [ppm_pkg::GAIN_W-1:0]      first_gain,
  output logic [ppm_pkg::GAIN_W-1:0]      second_gain
);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_min_code  <= SAMPLE_BITS'(ppm_pkg::FIRST_MIN_RST);
      first_max_code  <= SAMPLE_BITS'(ppm_pkg::FIRST_MAX_RST);
      second_min_code <= SAMPLE_BITS'(ppm_pkg::SECOND_MIN_RST);
      second_max_code <= SAMPLE_BITS'(ppm_pkg::SECOND_MAX_RST);
      timeout_us      <= ppm_pkg::TIMEOUT_RST;
      first_gain      <= ppm_pkg::FIRST_GAIN_RST;
      second_gain     <= ppm_pkg::SECOND_GAIN_RST;
    end else if (wr_en) begin
      case (wr_index)
        ppm_pkg::REG_FIRST_MIN:   first_min_code  <= wr_data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_FIRST_MAX:   first_max_code  <= wr_data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_SECOND_MIN:  second_min_code <= wr_data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_SECOND_MAX:  second_max_code <= wr_data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_TIMEOUT:     timeout_us      <= wr_data[ppm_pkg::ELAPSED_W-1:0];
        ppm_pkg::REG_FIRST_GAIN:  first_gain      <= wr_data[ppm_pkg::GAIN_W-1:0];
        ppm_pkg::REG_SECOND_GAIN: second_gain     <= wr_data[ppm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/ppm_check.sv]
`timescale 1ns / 1ps

module ppm_check #(
  parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF,
  localparam int PROD_W = SAMPLE_BITS + ppm_pkg::GAIN_W
) (
  input  logic [SAMPLE_BITS-1:0]      first_sample,
  input  logic [SAMPLE_BITS-1:0]      second_sample,
  input  logic [SAMPLE_BITS-1:0]      first_min_code,
  input  logic [SAMPLE_BITS-1:0]      first_max_code,
  input  logic [SAMPLE_BITS-1:0]      second_min_code,
  input  logic [SAMPLE_BITS-1:0]      second_max_code,
  input  logic [ppm_pkg::GAIN_W-1:0]  first_gain,
  input  logic [ppm_pkg::GAIN_W-1:0]  second_gain,
  output ppm_pkg::item_flags_t        flags,
  output logic [PROD_W-1:0]           first_prod,
  output logic [PROD_W-1:0]           second_prod
);

  localparam int TEN_W = SAMPLE_BITS + 4;

  logic [SAMPLE_BITS-1:0] diff;
  logic [TEN_W-1:0]       ten_diff;
  logic [SAMPLE_BITS-1:0] first_off;
  logic [SAMPLE_BITS-1:0] second_off;

  always_comb begin
    diff = (first_sample >= second_sample) ? (first_sample - second_sample)
                                           : (second_sample - first_sample);
    ten_diff = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
    flags.mismatch = (ten_diff >= TEN_W'(first_sample));
    flags.out_of_range = (first_sample > first_max_code) ||
                         (second_sample > second_max_code) ||
                         (first_sample < first_min_code) ||
                         (second_sample < second_min_code);
    // Offsets wrap when a sample is below its minimum; the demand is dropped then anyway
    first_off  = first_sample - first_min_code;
    second_off = second_sample - second_min_code;
    first_prod  = PROD_W'(first_off) * PROD_W'(first_gain);
    second_prod = PROD_W'(second_off) * PROD_W'(second_gain);
  end

endmodule

[src/pedal_plausibility_monitor_core.sv]
// Pairs pass the input stage, then the result register; one pair per cycle
// unless the output stalls. The input stage and the result register each
// hold one beat, so the output may stall without stopping intake at once.
// Reset (synchronous, active high) restores the register defaults, clears the
// implausibility timer and the fault latch, and empties both stages.
`timescale 1ns / 1ps
`include "pedal_plausibility_monitor_core_defines.svh"

module pedal_plausibility_monitor_core #(
  parameter int SAMPLE_BITS = ppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_BITS-1:0]           first_sample,
  input  logic [SAMPLE_BITS-1:0]           second_sample,
  input  logic [ppm_pkg::DELTA_W-1:0]      delta_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppm_pkg::STATUS_W-1:0]     status,
  output logic                             demand_valid,
  output logic [ppm_pkg::DEMAND_W-1:0]     demand_permille,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + ppm_pkg::GAIN_W;
  localparam int RND_W = PROD_W + 2;
  localparam int MEAN_W = RND_W - ppm_pkg::FRAC_BITS;

  logic [SAMPLE_BITS-1:0]         first_min_code;
  logic [SAMPLE_BITS-1:0]         first_max_code;
  logic [SAMPLE_BITS-1:0]         second_min_code;
  logic [SAMPLE_BITS-1:0]         second_max_code;
  logic [ppm_pkg::ELAPSED_W-1:0]  timeout_us;
  logic [ppm_pkg::GAIN_W-1:0]     first_gain;
  logic [ppm_pkg::GAIN_W-1:0]     second_gain;

  ppm_pkg::item_flags_t           chk_flags;
  logic [PROD_W-1:0]              chk_first_prod;
  logic [PROD_W-1:0]              chk_second_prod;

  // input stage
  logic                           s1_valid;
  ppm_pkg::item_flags_t           s1_flags;
  logic [PROD_W-1:0]              s1_first_prod;
  logic [PROD_W-1:0]              s1_second_prod;
  logic [ppm_pkg::DELTA_W-1:0]    s1_delta;

  // monitor state
  logic                           implausible_active;
  logic                           implausible_active_next;
  logic [ppm_pkg::ELAPSED_W-1:0]  elapsed_us;
  logic [ppm_pkg::ELAPSED_W-1:0]  elapsed_us_next;
  logic                           fault_latched;
  logic                           fault_latched_next;

  logic [ppm_pkg::STATUS_W-1:0]   status_next;
  logic                           demand_valid_next;
  logic [ppm_pkg::DEMAND_W-1:0]   demand_permille_next;

  logic                           in_fire;
  logic                           out_load;
  logic                           advance;
  logic [ppm_pkg::ELAPSED_W:0]    elapsed_sum;
  logic [ppm_pkg::ELAPSED_W-1:0]  elapsed_sat;
  logic [RND_W-1:0]               rounded;
  logic [MEAN_W-1:0]              mean;

  assign cfg_ready = 1'b1;

  ppm_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (cfg_valid & cfg_ready),
    .wr_index        (cfg_index),
    .wr_data         (cfg_data),
    .first_min_code  (first_min_code),
    .first_max_code  (first_max_code),
    .second_min_code (second_min_code),
    .second_max_code (second_max_code),
    .timeout_us      (timeout_us),
    .first_gain      (first_gain),
    .second_gain     (second_gain)
  );

  ppm_check #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .first_sample    (first_sample),
    .second_sample   (second_sample),
    .first_min_code  (first_min_code),
    .first_max_code  (first_max_code),
    .second_min_code (second_min_code),
    .second_max_code (second_max_code),
    .first_gain      (first_gain),
    .second_gain     (second_gain),
    .flags           (chk_flags),
    .first_prod      (chk_first_prod),
    .second_prod     (chk_second_prod)
  );

  assign out_load = !out_valid || out_ready;
  assign advance  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags       <= chk_flags;
      s1_first_prod  <= chk_first_prod;
      s1_second_prod <= chk_second_prod;
      s1_delta       <= delta_us;
    end
  end

  always_comb begin
    elapsed_sum = {1'b0, elapsed_us} + (ppm_pkg::ELAPSED_W + 1)'(s1_delta);
    elapsed_sat = elapsed_sum[ppm_pkg::ELAPSED_W] ? ppm_pkg::ELAPSED_MAX
                                                  : elapsed_sum[ppm_pkg::ELAPSED_W-1:0];
    // Q16 sum, round half up, then saturate
    rounded = RND_W'(s1_first_prod) + RND_W'(s1_second_prod)
            + RND_W'(1 << (ppm_pkg::FRAC_BITS - 1));
    mean = rounded[RND_W-1:ppm_pkg::FRAC_BITS];

    implausible_active_next = implausible_active;
    elapsed_us_next         = elapsed_us;
    fault_latched_next      = fault_latched;
    status_next             = ppm_pkg::STAT_FAULT;
    demand_valid_next       = 1'b0;
    demand_permille_next    = '0;

    if (fault_latched) begin
      status_next = ppm_pkg::STAT_FAULT;
    end else if (s1_flags.mismatch) begin
      status_next = ppm_pkg::STAT_MISMATCH;
    end else if (s1_flags.out_of_range) begin
      if (!implausible_active) begin
        implausible_active_next = 1'b1;
        elapsed_us_next         = '0;
        status_next             = ppm_pkg::STAT_PENDING;
      end else begin
        elapsed_us_next = elapsed_sat;
        if (elapsed_sat >= timeout_us) begin
          fault_latched_next = 1'b1;
          status_next        = ppm_pkg::STAT_FAULT;
        end else begin
          status_next = ppm_pkg::STAT_PENDING;
        end
      end
    end else begin
      implausible_active_next = 1'b0;
      elapsed_us_next         = '0;
      status_next             = ppm_pkg::STAT_DEMAND;
      demand_valid_next       = 1'b1;
      demand_permille_next    = (mean > MEAN_W'(ppm_pkg::DEMAND_MAX))
                                ? ppm_pkg::DEMAND_MAX
                                : mean[ppm_pkg::DEMAND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      implausible_active <= 1'b0;
      elapsed_us         <= '0;
      fault_latched      <= 1'b0;
    end else if (advance) begin
      implausible_active <= implausible_active_next;
      elapsed_us         <= elapsed_us_next;
      fault_latched      <= fault_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status          <= status_next;
      demand_valid    <= demand_valid_next;
      demand_permille <= demand_permille_next;
    end
  end

  `PPM_ASSERT_NEXT(a_fault_sticks, fault_latched, fault_latched,
    "fault latch dropped without reset")
  `PPM_ASSERT_NOW(a_timer_needs_active, (elapsed_us == '0) || implausible_active,
    "timer running while no implausibility")
  `PPM_ASSERT_NOW(a_demand_status,
    !(out_valid && demand_valid) ||
    (status == ppm_pkg::STAT_DEMAND && demand_permille <= ppm_pkg::DEMAND_MAX),
    "demand beat with bad status or range")
  `PPM_ASSERT_NOW(a_no_demand_zero,
    !out_valid || demand_valid || (demand_permille == '0),
    "demand value on a beat without demand")
  `PPM_ASSERT_NEXT(a_stage_held, s1_valid && !out_load, s1_valid,
    "input stage lost a beat while stalled")

endmodule

[verif/ppm_result_checker.sv]
`timescale 1ns / 1ps

module ppm_result_checker
  import ppm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] first_sample,
  input  logic [SAMPLE_BITS-1:0] second_sample,
  input  logic [DELTA_W-1:0]     delta_us,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [STATUS_W-1:0]    status,
  input  logic                   demand_valid,
  input  logic [DEMAND_W-1:0]    demand_permille,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     miscompares,
  output int                     results_due
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                demand_valid;
    logic [DEMAND_W-1:0] demand_permille;
  } pedal_result_t;

  logic [SAMPLE_BITS-1:0] win1_lo, win1_hi, win2_lo, win2_hi;
  logic [ELAPSED_W-1:0]   trip_limit;
  logic [GAIN_W-1:0]      gain1, gain2;
  logic                   trip_active, fault_set;
  logic [ELAPSED_W-1:0]   trip_elapsed;
  pedal_result_t          due_results[$];
  pedal_result_t          seen, want;

  initial miscompares = 0;
  initial results_due = 0;

  function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FIRST_MIN:   win1_lo = val[SAMPLE_BITS-1:0];
      REG_FIRST_MAX:   win1_hi = val[SAMPLE_BITS-1:0];
      REG_SECOND_MIN:  win2_lo = val[SAMPLE_BITS-1:0];
      REG_SECOND_MAX:  win2_hi = val[SAMPLE_BITS-1:0];
      REG_TIMEOUT:     trip_limit = val[ELAPSED_W-1:0];
      REG_FIRST_GAIN:  gain1 = val[GAIN_W-1:0];
      REG_SECOND_GAIN: gain2 = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the implausibility timer for one pair and form its result.
  function automatic pedal_result_t judge_pair(input logic [SAMPLE_BITS-1:0] a,
                                               input logic [SAMPLE_BITS-1:0] b,
                                               input logic [DELTA_W-1:0] dt);
    pedal_result_t r;
    int ia, ib, gap;
    logic [ELAPSED_W:0] grown;
    logic [47:0] travel;
    r.status = STAT_FAULT;
    r.demand_valid = 1'b0;
    r.demand_permille = '0;
    if (fault_set) return r;
    ia = a;
    ib = b;
    gap = (ia >= ib) ? ia - ib : ib - ia;
    if (10 * gap >= ia) begin
      r.status = STAT_MISMATCH;
      return r;
    end
    if (a < win1_lo || a > win1_hi || b < win2_lo || b > win2_hi) begin
      r.status = STAT_PENDING;
      if (!trip_active) begin
        trip_active = 1'b1;
        trip_elapsed = '0;
        return r;
      end
      grown = trip_elapsed + dt;
      trip_elapsed = (grown > ELAPSED_MAX) ? ELAPSED_MAX : grown[ELAPSED_W-1:0];
      if (trip_elapsed >= trip_limit) begin
        fault_set = 1'b1;
        r.status = STAT_FAULT;
      end
      return r;
    end
    trip_active = 1'b0;
    trip_elapsed = '0;
    // Q16 sum, round half up, then clamp to full travel
    travel = (a - win1_lo) * gain1 + (b - win2_lo) * gain2 + (48'd1 << (FRAC_BITS - 1));
    travel = travel >> FRAC_BITS;
    r.status = STAT_DEMAND;
    r.demand_valid = 1'b1;
    r.demand_permille = (travel > DEMAND_MAX) ? DEMAND_MAX : travel[DEMAND_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win1_lo = SAMPLE_BITS'(FIRST_MIN_RST);
      win1_hi = SAMPLE_BITS'(FIRST_MAX_RST);
      win2_lo = SAMPLE_BITS'(SECOND_MIN_RST);
      win2_hi = SAMPLE_BITS'(SECOND_MAX_RST);
      trip_limit = TIMEOUT_RST;
      gain1 = FIRST_GAIN_RST;
      gain2 = SECOND_GAIN_RST;
      trip_active = 1'b0;
      trip_elapsed = '0;
      fault_set = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        seen.status = status;
        seen.demand_valid = demand_valid;
        seen.demand_permille = demand_permille;
        if (due_results.size() == 0) begin
          $display("%0t ppm check: unexpected beat, status %0d demand_valid %0d demand %0d",
                   $time, seen.status, seen.demand_valid, seen.demand_permille);
          miscompares++;
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status) begin
            $display("%0t ppm check: status expected %0d actual %0d",
                     $time, want.status, seen.status);
            miscompares++;
          end
          if (seen.demand_valid !== want.demand_valid) begin
            $display("%0t ppm check: demand_valid expected %0d actual %0d",
                     $time, want.demand_valid, seen.demand_valid);
            miscompares++;
          end
          if (seen.demand_permille !== want.demand_permille) begin
            $display("%0t ppm check: demand_permille expected %0d actual %0d",
                     $time, want.demand_permille, seen.demand_permille);
            miscompares++;
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(judge_pair(first_sample, second_sample, delta_us));
    end
    results_due <= due_results.size();
  end

endmodule

[verif/pedal_plausibility_monitor_core_test.sv]
`timescale 1ns / 1ps

module pedal_plausibility_monitor_core_test;
  import ppm_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int CODE_TOP = (1 << SAMPLE_BITS) - 1;
  // no register lives at this index
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] first_sample = '0;
  logic [SAMPLE_BITS-1:0] second_sample = '0;
  logic [DELTA_W-1:0]     delta_us = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic                   demand_valid;
  logic [DEMAND_W-1:0]    demand_permille;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int miscompares, results_due;
  int send_idle_pct = 31;
  int recv_idle_pct = 70;
  bit choke_req = 1'b0;

  // stimulus-side copy of the windows and timeout, to keep the fault latch
  // from tripping before the last phase
  int win1_lo = FIRST_MIN_RST, win1_hi = FIRST_MAX_RST;
  int win2_lo = SECOND_MIN_RST, win2_hi = SECOND_MAX_RST;
  int trip_limit = TIMEOUT_RST;
  int run_us = 0;
  int since_clear = 0;

  pedal_plausibility_monitor_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_sample(first_sample), .second_sample(second_sample), .delta_us(delta_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .demand_valid(demand_valid), .demand_permille(demand_permille),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ppm_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_sample(first_sample), .second_sample(second_sample), .delta_us(delta_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .demand_valid(demand_valid), .demand_permille(demand_permille),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .miscompares(miscompares), .results_due(results_due)
  );

  always #2 clk = ~clk;

  task automatic send_pair(input int a, input int b, input int dt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    first_sample <= SAMPLE_BITS'(a);
    second_sample <= SAMPLE_BITS'(b);
    delta_us <= DELTA_W'(dt);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FIRST_MIN:  win1_lo = val[SAMPLE_BITS-1:0];
      REG_FIRST_MAX:  win1_hi = val[SAMPLE_BITS-1:0];
      REG_SECOND_MIN: win2_lo = val[SAMPLE_BITS-1:0];
      REG_SECOND_MAX: win2_hi = val[SAMPLE_BITS-1:0];
      REG_TIMEOUT:    trip_limit = val[ELAPSED_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid and wait until every result is out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Second code within the ten percent band of the first.
  function automatic int partner_code(input int a);
    int off, b;
    if (a == 0) return 0;
    off = $urandom_range((a - 1) / 10);
    b = $urandom_range(1) ? a + off : a - off;
    if (b > CODE_TOP) b = CODE_TOP;
    if (b < 0) b = 0;
    return b;
  endfunction

  task automatic send_clearing_pair();
    int lo, hi, a, b;
    lo = (win1_lo > win2_lo) ? win1_lo : win2_lo;
    if (lo < 1) lo = 1;
    hi = (win1_hi < win2_hi) ? win1_hi : win2_hi;
    a = $urandom_range(hi, lo);
    b = partner_code(a);
    if (b < win2_lo || b > win2_hi) b = a;
    send_pair(a, b, $urandom_range(16'hFFFF));
    run_us = 0;
    since_clear = 0;
  endtask

  task automatic send_random_pair();
    int a, b, dt, kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      a = $urandom_range(win1_hi, win1_lo);
      b = partner_code(a);
    end else if (kind < 65) begin
      if (win1_hi < CODE_TOP && (win1_lo <= 1 || $urandom_range(1)))
        a = $urandom_range(CODE_TOP, win1_hi + 1);
      else if (win1_lo > 1)
        a = $urandom_range(win1_lo - 1, 1);
      else
        a = $urandom_range(CODE_TOP);
      b = partner_code(a);
    end else if (kind < 80) begin
      // force the band test to fail, landing on its edge now and then
      a = $urandom_range(CODE_TOP);
      if (a > CODE_TOP / 2) begin
        b = a - (a + 9) / 10 - $urandom_range(a / 2);
      end else begin
        b = a + (a + 9) / 10 + $urandom_range(a);
        if (b > CODE_TOP) b = CODE_TOP;
      end
    end else begin
      a = $urandom_range(CODE_TOP);
      b = $urandom_range(CODE_TOP);
    end
    dt = $urandom_range(1) ? $urandom_range(16'hFFFF) : $urandom_range(4000);
    // clear the timer before it could reach the timeout
    if (since_clear > 0 && run_us + dt >= trip_limit) send_clearing_pair();
    send_pair(a, b, dt);
    if (since_clear > 0) run_us += dt;
    since_clear++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (choke_req) begin
        choke_req = 1'b0;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("pedal_plausibility_monitor_core: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_SPARE, 20'hFFFFF);

    send_pair(0, 0, 0);
    send_pair(1000, 1000, 0);
    send_pair(372, 372, 16'hFFFF);
    send_pair(2792, 2792, 0);
    send_pair(2000, 2200, 0);
    send_pair(2000, 2199, 0);
    send_pair(2000, 1800, 0);
    send_pair(2000, 1801, 0);
    send_pair(4095, 4095, 16'hFFFF);
    send_pair(4095, 4095, 16'hFFFF);
    send_pair(2000, 1000, 16'hFFFF);
    send_pair(4095, 4000, 34464);
    send_pair(1500, 1500, 0);
    send_pair(300, 300, 500);
    send_pair(2793, 2793, 1000);
    send_pair(1500, 1501, 0);
    send_pair(400, 371, 0);
    send_pair(3351, 3351, 0);
    send_pair(3000, 3351, 0);
    send_pair(2792, 2600, 0);
    send_pair(4095, 0, 0);
    send_pair(1, 0, 0);
    send_pair(1, 1, 0);
    send_pair(2000, 2000, 0);
    repeat (200) send_random_pair();

    settle();
    write_reg(REG_FIRST_MIN, 20'h00000);
    write_reg(REG_FIRST_MAX, 20'hFFFFF);
    write_reg(REG_SECOND_MIN, 20'h00000);
    write_reg(REG_SECOND_MAX, 20'hFFFFF);
    write_reg(REG_TIMEOUT, 20'd0);
    write_reg(REG_FIRST_GAIN, 20'hFFFFF);
    write_reg(REG_SECOND_GAIN, 20'hFFFFF);
    repeat (200) send_random_pair();

    settle();
    send_idle_pct = 70;
    recv_idle_pct = 31;
    write_reg(REG_FIRST_MIN, 20'd100);
    write_reg(REG_FIRST_MAX, 20'd1500);
    write_reg(REG_SECOND_MIN, 20'd200);
    write_reg(REG_SECOND_MAX, 20'd2000);
    write_reg(REG_TIMEOUT, 20'd1000000);
    write_reg(REG_FIRST_GAIN, 20'd0);
    write_reg(REG_SECOND_GAIN, 20'd30000);
    repeat (200) send_random_pair();

    // inverted windows: nothing can clear the timer, so start from a cleared
    // timer and keep deltas short
    send_clearing_pair();
    settle();
    write_reg(REG_FIRST_MIN, 20'd3000);
    write_reg(REG_FIRST_MAX, 20'd1000);
    write_reg(REG_SECOND_MIN, 20'd4095);
    write_reg(REG_SECOND_MAX, 20'd0);
    write_reg(REG_TIMEOUT, 20'hFFFFF);
    repeat (20) begin
      int a;
      a = $urandom_range(CODE_TOP);
      send_pair(a, partner_code(a), $urandom_range(40000));
    end
    run_us = 1 << 30;
    since_clear = 1;

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FIRST_MIN, 20'd500);
    write_reg(REG_FIRST_MAX, 20'd3500);
    write_reg(REG_SECOND_MIN, 20'd400);
    write_reg(REG_SECOND_MAX, 20'd3600);
    write_reg(REG_TIMEOUT, 20'd50000);
    write_reg(REG_FIRST_GAIN, 20'd9000);
    write_reg(REG_SECOND_GAIN, 20'd40000);
    write_reg(REG_SPARE, 20'h00000);
    choke_req = 1'b1;
    repeat (200) send_random_pair();

    // upper data bits must be dropped by the narrower registers
    settle();
    write_reg(REG_FIRST_MIN, 20'hFF320);
    write_reg(REG_FIRST_MAX, 20'h0ABB8);
    write_reg(REG_SECOND_MIN, 20'hA5384);
    write_reg(REG_SECOND_MAX, 20'h50C1C);
    write_reg(REG_TIMEOUT, 20'd25000);
    write_reg(REG_FIRST_GAIN, 20'hF1234);
    write_reg(REG_SECOND_GAIN, 20'h0FFFF);
    repeat (170) send_random_pair();

    // run the timer to exactly the timeout; the fault then holds to the end
    settle();
    write_reg(REG_TIMEOUT, 20'd70000);
    send_clearing_pair();
    send_pair(4095, 4095, 0);
    send_pair(4095, 4095, 69999);
    send_pair(4000, 4095, 1);
    send_pair(0, 0, 0);
    send_pair(1500, 1500, 0);
    repeat (25) send_random_pair();

    settle();
    if (miscompares == 0) begin
      $display("pedal_plausibility_monitor_core: match");
    end else begin
      $display("pedal_plausibility_monitor_core: mismatch");
    end
    $finish;
  end

endmodule

[pedal_plausibility_monitor_core.f]
+incdir+src
src/ppm_pkg.sv
src/ppm_cfg_regs.sv
src/ppm_check.sv
src/pedal_plausibility_monitor_core.sv
verif/ppm_result_checker.sv
verif/pedal_plausibility_monitor_core_test.sv
